### hw/rtl/eabb_pkg.sv
// Shared types, constants and helper functions for the edge-aware box blur.
// No dependencies; every other RTL file but eabb_ram imports this package.
`default_nettype none
package eabb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 13'd768;

  localparam int LS_ADDR_W = $clog2(MAX_WIDTH);
  localparam int LS_DATA_W = 2 * PIX_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int SUM_W       = 12;
  localparam int V_W         = 13;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = V_W + RECIP_W;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_pix_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_column;
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic             last_of_run;
    logic             frame_end;
  } out_pix_t;

  // One classified input: window after the shift plus where it sits in the frame.
  typedef struct packed {
    pix_t [8:0]       win;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             y_ge1;
    logic             y_ge2;
    logic             y_last;
    logic             x_ge1;
    logic             x_ge2;
    logic             x_last;
  } win_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    F_IDLE,
    F_READ
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_MUL,
    B_OUT
  } back_state_t;

  // ceil(2^16 / (2n)); exact for every dividend this block produces.
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd1:    m = 16'd32768;
      4'd2:    m = 16'd16384;
      4'd3:    m = 16'd10923;
      4'd4:    m = 16'd8192;
      4'd6:    m = 16'd5462;
      4'd9:    m = 16'd3641;
      default: m = 16'd32768;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/eabb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module eabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/eabb_front.sv
// Front end: config registers, line store, 3x3 window and output classification.
// Depends on eabb_pkg and eabb_ram.
`default_nettype none
module eabb_front import eabb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_pix_t               in_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  q_status_t             q_stat,
  output logic                  push,
  output win_entry_t            push_entry
);

  front_state_t     state_r, state_nxt;
  logic [FW_W-1:0]  w_r;
  logic [FH_W-1:0]  h_r;
  logic [COL_W-1:0] x_r;
  logic [ROW_W-1:0] y_r;
  pix_t [8:0]       win_r, win_nxt;
  pix_t             pix_r;
  logic [FW_W-1:0]  eff_w;
  logic [FH_W-1:0]  eff_h;
  logic             x_last, y_last;
  logic             accept, ram_we;
  logic [LS_DATA_W-1:0] ram_rdata;
  pix_t             top, mid;

  always_comb begin
    if (w_r == '0) eff_w = FW_W'(1);
    else if (w_r > FW_W'(MAX_WIDTH)) eff_w = FW_W'(MAX_WIDTH);
    else eff_w = w_r;
    if (h_r == '0) eff_h = FH_W'(1);
    else if (h_r > FH_W'(MAX_HEIGHT)) eff_h = FH_W'(MAX_HEIGHT);
    else eff_h = h_r;
  end

  assign x_last = ({1'b0, x_r} == eff_w - FW_W'(1));
  assign y_last = ({1'b0, y_r} == eff_h - FH_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_READ;
      F_READ:  state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    case (state_r)
      F_IDLE:  in_ready = !q_stat.full;
      F_READ:  ram_we   = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  eabb_ram #(.WIDTH(LS_DATA_W), .DEPTH(MAX_WIDTH)) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (x_r[LS_ADDR_W-1:0]),
    .wdata ({mid, pix_r}),
    .re    (accept),
    .raddr (x_r[LS_ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign top = ram_rdata[LS_DATA_W-1:PIX_W];
  assign mid = ram_rdata[PIX_W-1:0];

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = pix_r;
  end

  always_comb begin
    push_entry.win    = win_nxt;
    push_entry.row    = y_r;
    push_entry.col    = x_r;
    push_entry.y_ge1  = (y_r >= ROW_W'(1));
    push_entry.y_ge2  = (y_r >= ROW_W'(2));
    push_entry.y_last = y_last;
    push_entry.x_ge1  = (x_r >= COL_W'(1));
    push_entry.x_ge2  = (x_r >= COL_W'(2));
    push_entry.x_last = x_last;
  end

  // Drop items that cause no result instead of queueing them.
  assign push = (state_r == F_READ) &&
                ((push_entry.y_ge1 || y_last) && (push_entry.x_ge1 || x_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      w_r     <= FW_RESET;
      h_r     <= FH_RESET;
      x_r     <= '0;
      y_r     <= '0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT)) begin
        if (cfg_index == CFG_FRAME_WIDTH) w_r <= cfg_data[FW_W-1:0];
        else h_r <= cfg_data[FH_W-1:0];
        x_r   <= '0;
        y_r   <= '0;
        win_r <= '0;
      end else if (state_r == F_READ) begin
        win_r <= win_nxt;
        if (x_last) begin
          x_r <= '0;
          y_r <= y_last ? '0 : y_r + ROW_W'(1);
        end else begin
          x_r <= x_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= in_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/eabb_queue.sv
// Short queue of classified windows between the front and back ends.
// Depends on eabb_pkg.
`default_nettype none
module eabb_queue import eabb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  win_entry_t push_entry,
  input  logic       pop,
  output win_entry_t head,
  output q_status_t  q_stat
);

  win_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign head         = mem_r[rp_r];
  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + Q_PTR_W'(1);
      end
      if (push && !pop) cnt_r <= cnt_r + Q_CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/eabb_back.sv
// Back end: walks the results of one window, sums, divides and drives the output register.
// Depends on eabb_pkg.
`default_nettype none
module eabb_back import eabb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  win_entry_t head,
  input  q_status_t  q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_pix_t   out_data
);

  back_state_t          state_r, state_nxt;
  logic [1:0]           sub_r;
  logic [3:0]           pres;
  logic [2:0]           first_c, next_c;
  logic [2:0]           row_in, col_in;
  logic [1:0]           nr, nc;
  logic [3:0]           n;
  logic [SUM_W-1:0]     sr, sg, sb;
  logic [V_W-1:0]       v_r [3];
  logic [RECIP_W-1:0]   m_r;
  logic [PROD_W-1:0]    prod_r [3];
  logic [ROW_W-1:0]     row_r;
  logic [COL_W-1:0]     col_r;
  logic                 last_r, fend_r;
  logic                 out_valid_r, out_load;
  out_pix_t             out_data_r;

  // Smallest present combination at or after start; bit 2 flags a hit.
  function automatic logic [2:0] find_combo(input logic [3:0] p, input logic [2:0] start);
    logic [2:0] r;
    r = 3'b000;
    for (int j = 3; j >= 0; j--) begin
      if (p[j] && (3'(j) >= start)) r = {1'b1, 2'(j)};
    end
    return r;
  endfunction

  // Combination bit 1 picks the current row, bit 0 the current column.
  assign pres = {head.y_last && head.x_last, head.y_last && head.x_ge1,
                 head.y_ge1 && head.x_last, head.y_ge1 && head.x_ge1};
  assign first_c = find_combo(pres, 3'd0);
  assign next_c  = find_combo(pres, {1'b0, sub_r} + 3'd1);

  always_comb begin
    row_in = {1'b1, head.y_ge1, !sub_r[1] && head.y_ge2};
    col_in = {1'b1, head.x_ge1, !sub_r[0] && head.x_ge2};
    nr     = 2'($countones(row_in));
    nc     = 2'($countones(col_in));
    n      = {2'b00, nr} * {2'b00, nc};
    sr     = '0;
    sg     = '0;
    sb     = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_in[i] && col_in[j]) begin
          sr = sr + SUM_W'(head.win[i*3+j][3*CH_W-1:2*CH_W]);
          sg = sg + SUM_W'(head.win[i*3+j][2*CH_W-1:CH_W]);
          sb = sb + SUM_W'(head.win[i*3+j][CH_W-1:0]);
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_stat.empty) state_nxt = B_SUM;
      B_SUM:   state_nxt = B_MUL;
      B_MUL:   state_nxt = B_OUT;
      B_OUT:   if (out_load) state_nxt = last_r ? B_IDLE : B_SUM;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    pop      = 1'b0;
    case (state_r)
      B_OUT: begin
        out_load = !out_valid_r || out_ready;
        pop      = out_load && last_r;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_IDLE && !q_stat.empty) sub_r <= first_c[1:0];
      else if (out_load && !last_r) sub_r <= next_c[1:0];
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_SUM) begin
      v_r[0] <= {sr, 1'b0} + V_W'(n);
      v_r[1] <= {sg, 1'b0} + V_W'(n);
      v_r[2] <= {sb, 1'b0} + V_W'(n);
      m_r    <= recip(n);
      row_r  <= sub_r[1] ? head.row : head.row - ROW_W'(1);
      col_r  <= sub_r[0] ? head.col : head.col - COL_W'(1);
      last_r <= !next_c[2];
      fend_r <= (sub_r == 2'd3);
    end
    if (state_r == B_MUL) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PROD_W'(v_r[k]) * PROD_W'(m_r);
      end
    end
    if (out_load) begin
      out_data_r.out_row     <= row_r;
      out_data_r.out_column  <= col_r;
      out_data_r.red_out     <= prod_r[0][RECIP_SHIFT +: CH_W];
      out_data_r.green_out   <= prod_r[1][RECIP_SHIFT +: CH_W];
      out_data_r.blue_out    <= prod_r[2][RECIP_SHIFT +: CH_W];
      out_data_r.last_of_run <= last_r;
      out_data_r.frame_end   <= fend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### hw/rtl/edge_aware_box_blur_core.sv
// Each input pixel gets a line store read, then a write-back, before the next is accepted;
//   each result then passes through the back end states sum, multiply and output load.
// Reset (rst_n low, synchronous): control, positions and window cleared, frame size
//   back to 1024 x 768; line store contents are left as they are, no clearing pass.
// Depends on eabb_pkg, eabb_front, eabb_queue and eabb_back.
`default_nettype none
module edge_aware_box_blur_core import eabb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_pix_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_pix_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Config writes are always accepted; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  logic       push, pop;
  win_entry_t push_entry, head;
  q_status_t  q_stat;

  // Front: take a pixel transaction, read the two stored rows at this column,
  // advance the window and classify which neighborhoods it completes.
  eabb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: hold finished windows so the front keeps going while results stall.
  eabb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Back: emit up to four results per window in row-then-column order.
  eabb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### hw/rtl/eabb_checker.sv
// Port-level checks for the blur core, bound onto the top level.
// Depends on eabb_pkg and edge_aware_box_blur_core.
`default_nettype none
module eabb_checker import eabb_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_pix_t              out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.last_of_run)
    else $error("frame end not last of run");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted during line store write-back");

endmodule

bind edge_aware_box_blur_core eabb_checker u_eabb_checker (.*);
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for edge_aware_box_blur_core: a 3x3 edge-aware box blur.
// Holds its own blur predictor in a small scoreboard class; depends on eabb_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import eabb_pkg::*;

  localparam int SETTLE_CYCLES = 24;      // lets trailing no-result pixels clear the pipe
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 320;
  localparam int HOLD_CYCLES   = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Blur predictor plus the queue of blurred pixels still owed by the block.
  class blur_scoreboard;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    pix_t            line_mem[2*MAX_WIDTH];
    pix_t            win[9];
    int unsigned     row_pos, col_pos;
    out_pix_t        owed[$];
    int              errors;
    int              checked;

    function void restart();
      row_pos = 0;
      col_pos = 0;
      foreach (win[k]) win[k] = '0;
    endfunction

    function void reset_state();
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      errors     = 0;
      checked    = 0;
      restart();
    endfunction

    // Unknown indexes change nothing; a size write also restarts the frame.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH: begin
          width_reg = val[FW_W-1:0];
          restart();
        end
        CFG_FRAME_HEIGHT: begin
          height_reg = val[FH_W-1:0];
          restart();
        end
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    // Rounded mean of the in-image part of the neighborhood around window centre (rc, cc).
    function out_pix_t blur(int rc, int cc, int rbase, int cbase, int unsigned r,
                            int unsigned c, bit fend);
      int unsigned sr, sg, sb, n;
      out_pix_t    o;
      sr = 0; sg = 0; sb = 0; n = 0;
      for (int i = 0; i < 3; i++) begin
        if (i < rc - 1 || i > rc + 1 || rbase + i < 0) continue;
        for (int j = 0; j < 3; j++) begin
          if (j < cc - 1 || j > cc + 1 || cbase + j < 0) continue;
          sr += win[i*3+j][23:16];
          sg += win[i*3+j][15:8];
          sb += win[i*3+j][7:0];
          n++;
        end
      end
      o.out_row     = r[ROW_W-1:0];
      o.out_column  = c[COL_W-1:0];
      o.red_out     = 8'((2*sr + n) / (2*n));
      o.green_out   = 8'((2*sg + n) / (2*n));
      o.blue_out    = 8'((2*sb + n) / (2*n));
      o.last_of_run = 1'b0;
      o.frame_end   = fend;
      return o;
    endfunction

    function void note_pixel(in_pix_t p);
      int unsigned w, h, y, x, nr, nc, first;
      int unsigned rows[2], cols[2];
      int          rcent[2], ccent[2];
      pix_t        px, above2, above1;
      w = eff_w(); h = eff_h();
      y = row_pos; x = col_pos;
      nr = 0; nc = 0;
      if (y >= h) y = 0;
      if (x >= w) x = 0;
      px = {p.red_in, p.green_in, p.blue_in};
      above2 = line_mem[x];
      above1 = line_mem[MAX_WIDTH + x];
      line_mem[x] = above1;
      line_mem[MAX_WIDTH + x] = px;
      for (int a = 0; a < 3; a++) begin
        win[a*3]   = win[a*3+1];
        win[a*3+1] = win[a*3+2];
      end
      win[2] = above2;
      win[5] = above1;
      win[8] = px;
      if (y >= 1)     begin rows[nr] = y - 1; rcent[nr] = 1; nr++; end
      if (y == h - 1) begin rows[nr] = y;     rcent[nr] = 2; nr++; end
      if (x >= 1)     begin cols[nc] = x - 1; ccent[nc] = 1; nc++; end
      if (x == w - 1) begin cols[nc] = x;     ccent[nc] = 2; nc++; end
      first = owed.size();
      for (int a = 0; a < nr; a++)
        for (int b = 0; b < nc; b++)
          owed.push_back(blur(rcent[a], ccent[b], int'(y) - 2, int'(x) - 2, rows[a], cols[b],
                              rows[a] == h - 1 && cols[b] == w - 1));
      if (owed.size() > first) owed[owed.size()-1].last_of_run = 1'b1;
      if (x + 1 >= w) begin
        x = 0;
        y = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        x = x + 1;
      end
      row_pos = y;
      col_pos = x;
    endfunction

    function void check(out_pix_t got);
      out_pix_t want;
      if (owed.size() == 0) begin
        $error("unexpected blurred pixel row %0d col %0d", got.out_row, got.out_column);
        errors++;
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row); errors++;
      end
      if (got.out_column !== want.out_column) begin
        $error("out_column: expected %0d, got %0d", want.out_column, got.out_column); errors++;
      end
      if (got.red_out !== want.red_out) begin
        $error("red_out: expected %0d, got %0d", want.red_out, got.red_out); errors++;
      end
      if (got.green_out !== want.green_out) begin
        $error("green_out: expected %0d, got %0d", want.green_out, got.green_out); errors++;
      end
      if (got.blue_out !== want.blue_out) begin
        $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out); errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end); errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_pix_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_pix_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blur_scoreboard sb;
  int             cycles;
  int             pixels_sent;
  int             random_sent;
  int             phases_run;
  int             send_idle_pct;   // chance in a hundred that the sender idles a cycle
  int             recv_idle_pct;   // chance in a hundred that the receiver stalls a cycle
  bit             hold_done;
  bit             stim_done;

  edge_aware_box_blur_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d blurred pixels still owed", cycles,
               sb.owed.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Check every result transaction against the oldest owed pixel.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  // Drive out_ready. Once, in the middle of the random part and with results owed,
  // hold off for a long stretch so the internal queue fills and in_ready drops.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && random_sent >= 150 && sb.owed.size() > 0) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Pick the idle mix from progress through the random part.
  always @(posedge clk) begin
    if (random_sent < 110) begin
      send_idle_pct <= 10; recv_idle_pct <= 81;
    end else if (random_sent < 220) begin
      send_idle_pct <= 81; recv_idle_pct <= 10;
    end else begin
      send_idle_pct <= 0;  recv_idle_pct <= 0;
    end
  end

  // Offer one pixel, with random idle cycles in front; return once accepted.
  task automatic send_pixel(input logic [23:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rgb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(in_data);
    pixels_sent++;
  endtask

  // Wait for all owed pixels, then let trailing no-result pixels clear the pipe.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Idle the block, then program a new frame size.
  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w[CFG_DATA_W-1:0]);
    write_reg(CFG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
    phases_run++;
  endtask

  task automatic send_random(input int n, input bit counted);
    for (int k = 0; k < n; k++) begin
      send_pixel(24'($urandom()));
      if (counted) random_sent++;
    end
  endtask

  initial begin
    int unsigned w, h, n;
    sb = new();
    sb.reset_state();
    in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = CFG_FRAME_WIDTH; cfg_data = '0;
    rst_n = 1'b0;
    pixels_sent = 0; random_sent = 0; phases_run = 0;
    send_idle_pct = 10; recv_idle_pct = 81;
    hold_done = 1'b0; stim_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default 1024x768 first row produces nothing; channel extremes.
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFF00FF);
    // Spare register indexes are ignored and do not restart the frame.
    wait_idle();
    write_reg(CFG_SPARE_A, 13'h1FFF);
    write_reg(CFG_SPARE_B, 13'h0000);
    send_pixel(24'h00FF00);
    // 1x1 frame: each pixel comes back unchanged and ends its frame.
    set_frame(1, 1);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h123456);
    // Zero sizes clamp to one.
    set_frame(0, 0);
    send_pixel(24'hA5A5A5);
    send_pixel(24'h000000);
    // Single row and single column frames.
    set_frame(4, 1);
    repeat (4) send_pixel(24'($urandom()));
    set_frame(1, 3);
    repeat (3) send_pixel(24'($urandom()));
    // 3x3 frame plus one pixel wrapping into the next frame; all-max rounds back to 255.
    set_frame(3, 3);
    repeat (9) send_pixel(24'hFFFFFF);
    send_pixel(24'h010203);

    // Random frames: mostly small, complete frames with some wrap-around or cut short.
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(15))
        0: begin w = 2047; h = 2; end                    // over-wide clamps to full width
        1: begin w = $urandom_range(1, 3); h = 8191; end // over-tall clamps to max height
        2: begin w = 0; h = $urandom_range(1, 4); end
        default: begin w = $urandom_range(1, 9); h = $urandom_range(1, 6); end
      endcase
      if (w == 2047 && phases_run > 40) w = $urandom_range(2, 6);
      set_frame(w, h);
      w = sb.eff_w();
      h = sb.eff_h();
      if (w * h > 64) n = $urandom_range(8, 40);
      else n = w * h * $urandom_range(1, 2) + $urandom_range(0, 3) - $urandom_range(0, 1);
      send_random(n, 1'b1);
    end

    wait_idle();
    stim_done = 1'b1;
    if (sb.owed.size() != 0) begin
      $error("%0d blurred pixels never arrived", sb.owed.size());
      sb.errors++;
    end
    $display("covered %0d pixels over %0d frame settings, %0d blurred pixels checked",
             pixels_sent, phases_run, sb.checked);
    $display("sizes from 1x1 up to clamped over-wide and over-tall, with a long output stall");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
